FILE: design/arbd_pkg.sv
// ============================================================================
// arbd_pkg
// shared types and constants for the allele ratio breakpoint detector
// ============================================================================
package arbd_pkg;

  localparam int unsigned POS_W  = 31;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned RATE_W = 16;
  localparam int unsigned BSZ_W  = 13;

  // window reach either side and largest block, tied to the datapath widths
  localparam int unsigned HALF_WINDOW = 5;
  localparam int unsigned MAX_BLOCK   = 4096;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_SUPPORT = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] CFG_JUMP_THRESH = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_ACCUM,
    ST_CLOSE_DIV,
    ST_CLOSE_WR,
    ST_CHECK,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_BACK_DIV,
    ST_FWD_DIV,
    ST_JUDGE,
    ST_OUT,
    ST_END
  } arbd_state_t;

  // divider request
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } arbd_div_req_t;

  // divider status
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } arbd_div_rsp_t;

endpackage

FILE: design/arbd_ram.sv
// ============================================================================
// arbd_ram
// generic single write, single read ram with registered read data
// ============================================================================
module arbd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/arbd_div.sv
// ============================================================================
// arbd_div
// restoring divider, one quotient bit per cycle, 32 by 16 bits
// ============================================================================
module arbd_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  arbd_pkg::arbd_div_req_t req,
  output arbd_pkg::arbd_div_rsp_t rsp
);
  import arbd_pkg::*;

  logic [31:0] quo_r, quo_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  // one shift and subtract step
  always_comb begin
    trial    = {rem_r[15:0], quo_r[31]} - {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: design/allele_ratio_breakpoint_detector.sv
// ============================================================================
// allele_ratio_breakpoint_detector
// windowed block-mean change point detection on allele rates
// ============================================================================
// a kept record runs a rate divider pass and a dropped one skips it; closing a block adds
// a mean divider pass, and judging one adds back and forward window sums, each ending in a divider pass
// throughput: one record at a time; in_stall is high until its last result is queued
// reset: synchronous active low; counters clear, config returns to defaults,
// the block-mean ring is left unset and needs no clearing pass
module allele_ratio_breakpoint_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] in_position,
  input  logic [15:0] in_alt_count,
  input  logic [15:0] in_total_depth,
  input  logic        in_last_of_chrom,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_block_start_pos,
  output logic [15:0] out_back_mean,
  output logic [15:0] out_fwd_mean,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import arbd_pkg::*;

  localparam int unsigned RING  = 2 * HALF_WINDOW + 1;
  localparam int unsigned RA_W  = $clog2(RING);
  localparam int unsigned WN_W  = $clog2(HALF_WINDOW + 2);
  localparam logic [BSZ_W-1:0] MAX_BSZ = BSZ_W'(MAX_BLOCK);
  localparam logic [WN_W-1:0] HW = WN_W'(HALF_WINDOW);

  // configuration registers
  logic [7:0]       min_sup_r;
  logic [BSZ_W-1:0] bsz_r;
  logic [15:0]      thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sup_r <= 8'd8;
      bsz_r     <= BSZ_W'(1000);
      thr_r     <= 16'd1966;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SUPPORT: min_sup_r <= cfg_data[7:0];
        CFG_BLOCK_SIZE:  bsz_r     <= cfg_data[BSZ_W-1:0];
        CFG_JUMP_THRESH: thr_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // state
  arbd_state_t st_r, st_nxt;
  logic [28:0] sum_r, sum_nxt;
  logic [12:0] cnt_r, cnt_nxt;
  logic [30:0] opos_r, opos_nxt;
  logic [31:0] nblk_r, nblk_nxt;
  logic [31:0] nrep_r, nrep_nxt;
  logic [RA_W-1:0] wslot_r, wslot_nxt;   // slot of nblk
  logic [RA_W-1:0] jslot_r, jslot_nxt;   // slot of nrep
  logic [30:0] ipos_r, ipos_nxt;
  logic [15:0] ia_r, ia_nxt, it_r, it_nxt;
  logic        ilast_r, ilast_nxt;
  logic        flush_r, flush_nxt;
  logic [18:0] wsum_r, wsum_nxt;
  logic [WN_W-1:0] k_r, k_nxt, nb_r, nb_nxt, nf_r, nf_nxt;
  logic        fwd_r, fwd_nxt;
  logic [RA_W-1:0] rdslot_r, rdslot_nxt;
  logic [15:0] bm_r, bm_nxt, fm_r, fm_nxt;
  logic        pend_r, pend_nxt;
  logic        ov_r, ov_nxt;
  logic [30:0] opos_out_r, opos_out_nxt;
  logic [30:0] obp_r, obp_nxt;
  logic [15:0] obm_r, obm_nxt, ofm_r, ofm_nxt;
  logic        olast_r, olast_nxt;
  // held hit, kept apart from the output register
  logic [30:0] hpos_r, hpos_nxt;
  logic [15:0] hbm_r, hbm_nxt, hfm_r, hfm_nxt;

  arbd_div_req_t dreq;
  arbd_div_rsp_t drsp;

  logic            mwe, pwe;
  logic [RA_W-1:0] rd_addr;
  logic [15:0]     m_rd;
  logic [30:0]     p_rd;

  arbd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  arbd_ram #(.WIDTH(16), .DEPTH(RING)) u_means (
    .clk(clk), .wr_en(mwe), .wr_addr(wslot_r), .wr_data(drsp.quotient[15:0]),
    .rd_addr(rd_addr), .rd_data(m_rd));

  arbd_ram #(.WIDTH(31), .DEPTH(RING)) u_pos (
    .clk(clk), .wr_en(pwe), .wr_addr(wslot_r), .wr_data(opos_r),
    .rd_addr(rd_addr), .rd_data(p_rd));

  function automatic logic [RA_W-1:0] slot_inc(input logic [RA_W-1:0] s);
    return (s == RA_W'(RING - 1)) ? '0 : s + RA_W'(1);
  endfunction

  function automatic logic [RA_W-1:0] slot_dec(input logic [RA_W-1:0] s);
    return (s == '0) ? RA_W'(RING - 1) : s - RA_W'(1);
  endfunction

  logic [15:0]      other;
  logic             pass;
  logic [BSZ_W-1:0] eff;
  logic [31:0]      gap, ahead;
  logic [15:0]      diff;

  assign in_stall = (st_r != ST_IDLE);
  assign rd_addr  = rdslot_r;

  // sequencer
  always_comb begin
    st_nxt = st_r; sum_nxt = sum_r; cnt_nxt = cnt_r; opos_nxt = opos_r;
    nblk_nxt = nblk_r; nrep_nxt = nrep_r; wslot_nxt = wslot_r; jslot_nxt = jslot_r;
    ipos_nxt = ipos_r; ia_nxt = ia_r; it_nxt = it_r; ilast_nxt = ilast_r;
    flush_nxt = flush_r; wsum_nxt = wsum_r; k_nxt = k_r; nb_nxt = nb_r; nf_nxt = nf_r;
    fwd_nxt = fwd_r; rdslot_nxt = rdslot_r; bm_nxt = bm_r; fm_nxt = fm_r;
    pend_nxt = pend_r; ov_nxt = ov_r; opos_out_nxt = opos_out_r;
    obp_nxt = obp_r; obm_nxt = obm_r; ofm_nxt = ofm_r; olast_nxt = olast_r;
    hpos_nxt = hpos_r; hbm_nxt = hbm_r; hfm_nxt = hfm_r;
    dreq = '0; mwe = 1'b0; pwe = 1'b0;
    other = it_r - ia_r;
    pass  = (ia_r <= it_r) && (ia_r > 16'(min_sup_r)) && (other > 16'(min_sup_r));
    eff   = (bsz_r == '0) ? BSZ_W'(1) : ((bsz_r > MAX_BSZ) ? MAX_BSZ : bsz_r);
    gap   = nblk_r - nrep_r;
    ahead = nblk_r - 32'd1 - nrep_r;
    diff  = (fm_r > bm_r) ? fm_r - bm_r : bm_r - fm_r;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          ipos_nxt = in_position; ia_nxt = in_alt_count;
          it_nxt = in_total_depth; ilast_nxt = in_last_of_chrom;
          flush_nxt = 1'b0;
          st_nxt = ST_RATE_DIV;
        end
      end
      ST_RATE_DIV: begin
        if (pass) begin
          dreq.start    = 1'b1;
          dreq.dividend = {(ia_r < other) ? ia_r : other, 16'd0};
          dreq.divisor  = it_r;
          st_nxt = ST_ACCUM;
        end else begin
          st_nxt = ST_CHECK;
        end
      end
      ST_ACCUM: begin
        if (drsp.done) begin
          if (cnt_r == '0) opos_nxt = ipos_r;
          sum_nxt = sum_r + 29'(drsp.quotient[16:0]);
          cnt_nxt = cnt_r + 13'd1;
          st_nxt  = (cnt_r + 13'd1 >= eff) ? ST_CLOSE_DIV : ST_CHECK;
        end
      end
      ST_CLOSE_DIV: begin
        if (!drsp.busy && !drsp.done) begin
          dreq.start    = 1'b1;
          dreq.dividend = {3'd0, sum_r};
          dreq.divisor  = 16'(cnt_r);
          st_nxt = ST_CLOSE_WR;
        end
      end
      ST_CLOSE_WR: begin
        if (drsp.done) begin
          mwe = 1'b1; pwe = 1'b1;
          nblk_nxt = nblk_r + 32'd1;
          wslot_nxt = slot_inc(wslot_r);
          sum_nxt = '0; cnt_nxt = '0;
          st_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (gap > 32'(HALF_WINDOW) || (flush_r && gap != 32'd0)) begin
          nb_nxt = (nrep_r >= 32'(HALF_WINDOW)) ? HW : WN_W'(nrep_r);
          nb_nxt = nb_nxt + WN_W'(1);
          nf_nxt = (ahead < 32'(HALF_WINDOW)) ? WN_W'(ahead) : HW;
          nf_nxt = nf_nxt + WN_W'(1);
          k_nxt = '0; wsum_nxt = '0; fwd_nxt = 1'b0;
          rdslot_nxt = jslot_r;
          st_nxt = ST_SUM_RD;
        end else if (ilast_r && !flush_r) begin
          flush_nxt = 1'b1;
          if (cnt_r != '0) st_nxt = ST_CLOSE_DIV;
        end else begin
          st_nxt = ST_END;
        end
      end
      ST_SUM_RD: st_nxt = ST_SUM_ACC;
      ST_SUM_ACC: begin
        wsum_nxt = wsum_r + 19'(m_rd);
        if (k_r == '0 && !fwd_r) opos_out_nxt = p_rd;
        if (k_r + WN_W'(1) == (fwd_r ? nf_r : nb_r)) begin
          dreq.start    = 1'b1;
          dreq.dividend = 32'(wsum_r + 19'(m_rd));
          dreq.divisor  = 16'(fwd_r ? nf_r : nb_r);
          st_nxt = fwd_r ? ST_FWD_DIV : ST_BACK_DIV;
        end else begin
          k_nxt = k_r + WN_W'(1);
          rdslot_nxt = fwd_r ? slot_inc(rdslot_r) : slot_dec(rdslot_r);
          st_nxt = ST_SUM_RD;
        end
      end
      ST_BACK_DIV: begin
        if (drsp.done) begin
          bm_nxt = drsp.quotient[15:0];
          fwd_nxt = 1'b1; k_nxt = '0; wsum_nxt = '0;
          rdslot_nxt = jslot_r;
          st_nxt = ST_SUM_RD;
        end
      end
      ST_FWD_DIV: begin
        if (drsp.done) begin
          fm_nxt = drsp.quotient[15:0];
          st_nxt = ST_JUDGE;
        end
      end
      ST_JUDGE: begin
        nrep_nxt = nrep_r + 32'd1;
        jslot_nxt = slot_inc(jslot_r);
        st_nxt = ST_CHECK;
        if (diff > thr_r) begin
          // a second hit sends the held one first, then takes its place
          if (pend_r) begin
            st_nxt = ST_OUT;
          end else begin
            pend_nxt = 1'b1;
            hpos_nxt = opos_out_r; hbm_nxt = bm_r; hfm_nxt = fm_r;
          end
        end
      end
      ST_OUT: begin
        // emit the held hit as not last and hold the new one
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          olast_nxt = 1'b0;
          obp_nxt = hpos_r; obm_nxt = hbm_r; ofm_nxt = hfm_r;
          hpos_nxt = opos_out_r; hbm_nxt = bm_r; hfm_nxt = fm_r;
          st_nxt = ST_CHECK;
        end
      end
      ST_END: begin
        if (ilast_r) begin
          nblk_nxt = '0; nrep_nxt = '0; sum_nxt = '0; cnt_nxt = '0;
          wslot_nxt = '0; jslot_nxt = '0;
        end
        if (pend_r) begin
          if (!ov_r || !out_stall) begin
            ov_nxt = 1'b1; olast_nxt = 1'b1; pend_nxt = 1'b0;
            obp_nxt = hpos_r; obm_nxt = hbm_r; ofm_nxt = hfm_r;
            st_nxt = ST_IDLE;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; sum_r <= '0; cnt_r <= '0; opos_r <= '0;
      nblk_r <= '0; nrep_r <= '0; wslot_r <= '0; jslot_r <= '0;
      flush_r <= 1'b0; pend_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; sum_r <= sum_nxt; cnt_r <= cnt_nxt; opos_r <= opos_nxt;
      nblk_r <= nblk_nxt; nrep_r <= nrep_nxt; wslot_r <= wslot_nxt;
      jslot_r <= jslot_nxt; flush_r <= flush_nxt; pend_r <= pend_nxt; ov_r <= ov_nxt;
    end
    ipos_r <= ipos_nxt; ia_r <= ia_nxt; it_r <= it_nxt; ilast_r <= ilast_nxt;
    wsum_r <= wsum_nxt; k_r <= k_nxt; nb_r <= nb_nxt; nf_r <= nf_nxt;
    fwd_r <= fwd_nxt; rdslot_r <= rdslot_nxt; bm_r <= bm_nxt; fm_r <= fm_nxt;
    opos_out_r <= opos_out_nxt; olast_r <= olast_nxt;
    obp_r <= obp_nxt; obm_r <= obm_nxt; ofm_r <= ofm_nxt;
    hpos_r <= hpos_nxt; hbm_r <= hbm_nxt; hfm_r <= hfm_nxt;
  end

  assign out_valid           = ov_r;
  assign out_block_start_pos = obp_r;
  assign out_back_mean       = obm_r;
  assign out_fwd_mean        = ofm_r;
  assign out_last_result     = olast_r;

endmodule
